// ----- rtl/core/bounded_ordered_list_engine_top_macros.svh -----
// Assertion macros shared by the list engine RTL
`ifndef BOUNDED_ORDERED_LIST_ENGINE_TOP_MACROS_SVH
`define BOUNDED_ORDERED_LIST_ENGINE_TOP_MACROS_SVH

// check the consequent in the same cycle as the antecedent
`define BOLE_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// check the consequent in the cycle after the antecedent
`define BOLE_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/core/bole_pkg.sv -----
package bole_pkg;

   localparam int DATA_W       = 32;
   localparam int POS_W        = 8;
   localparam int COUNT_W      = 9;
   localparam int CMD_W        = 4;
   localparam int STAT_W       = 2;
   localparam int DEF_CAPACITY = 16;

   localparam logic [DATA_W-1:0]  MISSING_VALUE = '1;
   localparam logic [COUNT_W-1:0] NO_INDEX      = '1;

   typedef enum logic [CMD_W-1:0] {
      CMD_ADDFRONT = 4'd0,
      CMD_ADDBACK  = 4'd1,
      CMD_ADDAT    = 4'd2,
      CMD_RMFRONT  = 4'd3,
      CMD_RMBACK   = 4'd4,
      CMD_RMAT     = 4'd5,
      CMD_ISIN     = 4'd6,
      CMD_GETFRONT = 4'd7,
      CMD_GETAT    = 4'd8,
      CMD_INDEXOF  = 4'd9,
      CMD_LENGTH   = 4'd10,
      CMD_CLEAR    = 4'd11
   } cmd_type;

   typedef enum logic [STAT_W-1:0] {
      STAT_OK   = 2'd0,
      STAT_FULL = 2'd1,
      STAT_MISS = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_LOOK,
      S_APPLY,
      S_SEND
   } state_type;

   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_LOOK,
      CELL_INSERT,
      CELL_REMOVE
   } cell_op_type;

   typedef struct packed {
      cell_op_type          op;
      logic [COUNT_W-1:0]   where;
      logic [DATA_W-1:0]    key;
      logic [COUNT_W-1:0]   occupancy;
   } cell_ctrl_type;

endpackage

// ----- rtl/core/bole_cell.sv -----
module bole_cell
   import bole_pkg::*;
#(
   parameter int CELL_IDX = 0
) (
   input  logic                clock,
   input  logic                reset,
   input  cell_ctrl_type       ctrl,
   input  logic [DATA_W-1:0]   left_value,
   input  logic [DATA_W-1:0]   right_value,
   output logic [DATA_W-1:0]   value,
   output logic                match
);

   localparam logic [COUNT_W-1:0] MY_IDX = COUNT_W'(CELL_IDX);

   logic [DATA_W-1:0] value_ff, value_in;
   logic              match_ff, match_in;

   always_comb begin
      value_in = value_ff;
      match_in = match_ff;
      case (ctrl.op)
         CELL_LOOK: begin
            match_in = (MY_IDX < ctrl.occupancy) && (value_ff == ctrl.key);
         end
         CELL_INSERT: begin
            if (MY_IDX > ctrl.where) begin
               value_in = left_value;
            end else if (MY_IDX == ctrl.where) begin
               value_in = ctrl.key;
            end
         end
         CELL_REMOVE: begin
            if (MY_IDX >= ctrl.where) begin
               value_in = right_value;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         match_ff <= 1'b0;
      end else begin
         match_ff <= match_in;
      end
   end

   assign value = value_ff;
   assign match = match_ff;

endmodule

// ----- rtl/core/bole_pick.sv -----
module bole_pick
   import bole_pkg::*;
#(
   parameter int CAPACITY = DEF_CAPACITY
) (
   input  logic [DATA_W-1:0]            values [CAPACITY],
   input  logic [CAPACITY-1:0]          match,
   input  logic [COUNT_W-1:0]           where,
   output logic [DATA_W-1:0]            read_value,
   output logic                         found,
   output logic [$clog2(CAPACITY)-1:0]  first_index
);

   localparam int IDX_W = $clog2(CAPACITY);

   assign read_value = values[where[IDX_W-1:0]];
   assign found      = |match;

   always_comb begin
      first_index = '0;
      for (int i = CAPACITY - 1; i >= 0; i--) begin
         if (match[i]) begin
            first_index = IDX_W'(i);
         end
      end
   end

endmodule

// ----- rtl/core/bounded_ordered_list_engine_top.sv -----
// Ordered list engine: holds up to CAPACITY signed 32-bit values, front at index 0.
// Request channel (req_valid / req_stall) carries command, item_value and position;
// a request is taken at an edge with req_valid high and req_stall low.
// Response channel (rsp_valid / rsp_stall) returns one response per request:
// result_value, hit, found_index, entry_count and status.
// Each request runs three internal steps: capture, a compare pass through the cell
// chain that registers a match flag in every cell, then the apply step where the
// priority encoder and read mux pick the result while the cells shift.
// rsp_valid rises after the apply step has registered the result, in the send state.
// The next request is taken at the earliest in the cycle after the response is
// accepted, so the engine never takes a request before the last one is answered.
// While rsp_stall is high the response holds and no new request is taken.
// Synchronous reset empties the list (entry count zero) and returns to idle;
// stored values are not cleared and are never read beyond the entry count.
module bounded_ordered_list_engine_top
   import bole_pkg::*;
#(
   parameter int CAPACITY = DEF_CAPACITY
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic [CMD_W-1:0]           req_command,
   input  logic signed [DATA_W-1:0]   req_item_value,
   input  logic [POS_W-1:0]           req_position,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic signed [DATA_W-1:0]   rsp_result_value,
   output logic                       rsp_hit,
   output logic signed [COUNT_W-1:0]  rsp_found_index,
   output logic [COUNT_W-1:0]         rsp_entry_count,
   output logic [STAT_W-1:0]          rsp_status
);

`include "bounded_ordered_list_engine_top_macros.svh"

   localparam int IDX_W = $clog2(CAPACITY);
   localparam int CNT_W = $clog2(CAPACITY + 1);

   state_type            state_ff, state_in;
   logic [CNT_W-1:0]     occ_ff, occ_in;
   cmd_type              cmd_ff;
   logic [DATA_W-1:0]    item_ff;
   logic [POS_W-1:0]     pos_ff;

   logic [DATA_W-1:0]    rsp_value_ff, res_value;
   logic                 rsp_hit_ff, res_hit;
   logic [COUNT_W-1:0]   rsp_index_ff, res_index;
   logic [COUNT_W-1:0]   rsp_count_ff, res_count;
   status_type           rsp_status_ff, res_status;

   cell_ctrl_type        cell_ctrl;
   logic [DATA_W-1:0]    chain_value [CAPACITY];
   logic [CAPACITY-1:0]  chain_match;

   logic [COUNT_W-1:0]   occ9, pos9, where;
   logic [DATA_W-1:0]    pick_value;
   logic                 pick_found;
   logic [IDX_W-1:0]     pick_index;

   assign occ9 = COUNT_W'(occ_ff);
   assign pos9 = COUNT_W'(pos_ff);

   always_comb begin
      case (cmd_ff)
         CMD_ADDFRONT, CMD_RMFRONT, CMD_GETFRONT: where = '0;
         CMD_ADDBACK:                             where = occ9;
         CMD_RMBACK:                              where = occ9 - 1'b1;
         CMD_ADDAT:                               where = (pos9 > occ9) ? occ9 : pos9;
         default:                                 where = pos9;
      endcase
   end

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic [DATA_W-1:0] left_value, right_value;
      if (i == 0) begin : g_first
         assign left_value = chain_value[i];
      end else begin : g_left
         assign left_value = chain_value[i-1];
      end
      if (i == CAPACITY - 1) begin : g_last
         assign right_value = chain_value[i];
      end else begin : g_right
         assign right_value = chain_value[i+1];
      end
      bole_cell #(
         .CELL_IDX(i)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctrl       (cell_ctrl),
         .left_value (left_value),
         .right_value(right_value),
         .value      (chain_value[i]),
         .match      (chain_match[i])
      );
   end

   bole_pick #(
      .CAPACITY(CAPACITY)
   ) u_pick (
      .values     (chain_value),
      .match      (chain_match),
      .where      (where),
      .read_value (pick_value),
      .found      (pick_found),
      .first_index(pick_index)
   );

   always_comb begin
      state_in            = state_ff;
      occ_in              = occ_ff;
      cell_ctrl.op        = CELL_HOLD;
      cell_ctrl.where     = where;
      cell_ctrl.key       = item_ff;
      cell_ctrl.occupancy = occ9;
      res_value           = '0;
      res_hit             = 1'b0;
      res_index           = NO_INDEX;
      res_status          = STAT_OK;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               state_in = S_LOOK;
            end
         end
         S_LOOK: begin
            cell_ctrl.op = CELL_LOOK;
            state_in     = S_APPLY;
         end
         S_APPLY: begin
            state_in = S_SEND;
            case (cmd_ff)
               CMD_ADDFRONT, CMD_ADDBACK, CMD_ADDAT: begin
                  if (occ9 < COUNT_W'(CAPACITY)) begin
                     cell_ctrl.op = CELL_INSERT;
                     occ_in       = occ_ff + 1'b1;
                  end else begin
                     res_status = STAT_FULL;
                  end
               end
               CMD_RMFRONT, CMD_RMBACK, CMD_RMAT: begin
                  if (occ_ff != '0 && where < occ9) begin
                     cell_ctrl.op = CELL_REMOVE;
                     occ_in       = occ_ff - 1'b1;
                     res_value    = pick_value;
                     res_hit      = 1'b1;
                  end else begin
                     res_value  = MISSING_VALUE;
                     res_status = STAT_MISS;
                  end
               end
               CMD_GETFRONT, CMD_GETAT: begin
                  if (where < occ9) begin
                     res_value = pick_value;
                     res_hit   = 1'b1;
                  end else begin
                     res_value  = MISSING_VALUE;
                     res_status = STAT_MISS;
                  end
               end
               CMD_ISIN, CMD_INDEXOF: begin
                  res_hit = pick_found;
                  if (!pick_found) begin
                     res_status = STAT_MISS;
                  end
                  if (cmd_ff == CMD_INDEXOF && pick_found) begin
                     res_index = COUNT_W'(pick_index);
                  end
               end
               CMD_CLEAR: begin
                  occ_in = '0;
               end
               default: begin
               end
            endcase
         end
         S_SEND: begin
            if (!rsp_stall) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
      res_count = COUNT_W'(occ_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         occ_ff   <= '0;
      end else begin
         state_ff <= state_in;
         occ_ff   <= occ_in;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_IDLE) begin
         cmd_ff  <= cmd_type'(req_command);
         item_ff <= req_item_value;
         pos_ff  <= req_position;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_APPLY) begin
         rsp_value_ff  <= res_value;
         rsp_hit_ff    <= res_hit;
         rsp_index_ff  <= res_index;
         rsp_count_ff  <= res_count;
         rsp_status_ff <= res_status;
      end
   end

   assign req_stall        = (state_ff != S_IDLE);
   assign rsp_valid        = (state_ff == S_SEND);
   assign rsp_result_value = rsp_value_ff;
   assign rsp_hit          = rsp_hit_ff;
   assign rsp_found_index  = rsp_index_ff;
   assign rsp_entry_count  = rsp_count_ff;
   assign rsp_status       = rsp_status_ff;

   `BOLE_ASSERT_NOW(a_occ_bound, 1'b1, occ9 <= COUNT_W'(CAPACITY), "entry count above capacity")
   `BOLE_ASSERT_NEXT(a_occ_only_apply, state_ff != S_APPLY, $stable(occ_ff),
      "count moved outside apply")
   `BOLE_ASSERT_NEXT(a_apply_to_send, state_ff == S_APPLY, rsp_valid, "no response after apply")
   `BOLE_ASSERT_NOW(a_count_match, rsp_valid, rsp_entry_count == occ9, "response count mismatch")
   `BOLE_ASSERT_NOW(a_hit_ok, rsp_valid && rsp_hit, rsp_status == STAT_OK, "hit with bad status")
   `BOLE_ASSERT_NOW(a_full_count, rsp_valid && rsp_status == STAT_FULL,
      rsp_entry_count == COUNT_W'(CAPACITY), "full drop below capacity")

endmodule

// ----- test/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
   import bole_pkg::*;

   localparam int LIST_CAP     = DEF_CAPACITY;
   localparam int DRAIN_CYCLES = 8;
   localparam int MAX_REPORTS  = 10;
   localparam int RESET_CYCLES = 6;

   localparam logic [CMD_W-1:0] CMD_SPARE_LO = 4'd12;
   localparam logic [CMD_W-1:0] CMD_SPARE_HI = 4'd15;

   typedef struct packed {
      logic signed [DATA_W-1:0]  value;
      logic                      hit;
      logic signed [COUNT_W-1:0] index;
      logic [COUNT_W-1:0]        count;
      logic [STAT_W-1:0]         status;
   } list_response_type;

   logic                      clock          = 1'b0;
   logic                      reset          = 1'b1;
   logic                      req_valid      = 1'b0;
   logic                      req_stall;
   logic [CMD_W-1:0]          req_command    = '0;
   logic signed [DATA_W-1:0]  req_item_value = '0;
   logic [POS_W-1:0]          req_position   = '0;
   logic                      rsp_valid;
   logic                      rsp_stall      = 1'b0;
   logic signed [DATA_W-1:0]  rsp_result_value;
   logic                      rsp_hit;
   logic signed [COUNT_W-1:0] rsp_found_index;
   logic [COUNT_W-1:0]        rsp_entry_count;
   logic [STAT_W-1:0]         rsp_status;

   logic signed [DATA_W-1:0] list_values [LIST_CAP];
   int                       list_len = 0;
   list_response_type        pending_responses [$];

   int send_idle_pct  = 0;
   int rsp_idle_pct   = 0;
   int mismatch_count = 0;
   int request_count  = 0;
   int response_count = 0;
   int full_drops     = 0;
   int miss_count     = 0;
   int peak_len       = 0;

   bounded_ordered_list_engine_top #(.CAPACITY(LIST_CAP)) u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_command      (req_command),
      .req_item_value   (req_item_value),
      .req_position     (req_position),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_result_value (rsp_result_value),
      .rsp_hit          (rsp_hit),
      .rsp_found_index  (rsp_found_index),
      .rsp_entry_count  (rsp_entry_count),
      .rsp_status       (rsp_status)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   function automatic void apply_list_command(input logic [CMD_W-1:0] cmd,
                                              input logic signed [DATA_W-1:0] val,
                                              input logic [POS_W-1:0] pos,
                                              output list_response_type r);
      int where;
      int i;
      r.value  = '0;
      r.hit    = 1'b0;
      r.index  = NO_INDEX;
      r.status = STAT_OK;
      case (cmd)
         CMD_ADDFRONT, CMD_ADDBACK, CMD_ADDAT: begin
            if (cmd == CMD_ADDFRONT)
               where = 0;
            else if (cmd == CMD_ADDBACK || int'(pos) > list_len)
               where = list_len;
            else
               where = int'(pos);
            if (list_len < LIST_CAP) begin
               for (i = list_len; i > where; i--)
                  list_values[i] = list_values[i - 1];
               list_values[where] = val;
               list_len++;
            end else begin
               r.status = STAT_FULL;
            end
         end
         CMD_RMFRONT, CMD_RMBACK, CMD_RMAT: begin
            where = (cmd == CMD_RMFRONT) ? 0 :
                    (cmd == CMD_RMBACK) ? list_len - 1 : int'(pos);
            if (list_len != 0 && where < list_len) begin
               r.value = list_values[where];
               r.hit   = 1'b1;
               for (i = where; i + 1 < list_len; i++)
                  list_values[i] = list_values[i + 1];
               list_len--;
            end else begin
               r.value  = MISSING_VALUE;
               r.status = STAT_MISS;
            end
         end
         CMD_GETFRONT, CMD_GETAT: begin
            where = (cmd == CMD_GETFRONT) ? 0 : int'(pos);
            if (where < list_len) begin
               r.value = list_values[where];
               r.hit   = 1'b1;
            end else begin
               r.value  = MISSING_VALUE;
               r.status = STAT_MISS;
            end
         end
         CMD_ISIN, CMD_INDEXOF: begin
            where = -1;
            for (i = list_len - 1; i >= 0; i--)
               if (list_values[i] == val)
                  where = i;
            if (where >= 0)
               r.hit = 1'b1;
            else
               r.status = STAT_MISS;
            if (cmd == CMD_INDEXOF && where >= 0)
               r.index = where[COUNT_W-1:0];
         end
         CMD_CLEAR: list_len = 0;
         default: ;
      endcase
      r.count = list_len[COUNT_W-1:0];
      if (r.status == STAT_FULL)
         full_drops++;
      if (r.status == STAT_MISS)
         miss_count++;
      if (list_len > peak_len)
         peak_len = list_len;
   endfunction

   task automatic send_request(input logic [CMD_W-1:0] cmd,
                               input logic signed [DATA_W-1:0] val,
                               input logic [POS_W-1:0] pos);
      list_response_type r;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_command    <= cmd;
      req_item_value <= val;
      req_position   <= pos;
      // hold the request until taken
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      apply_list_command(cmd, val, pos, r);
      pending_responses.push_back(r);
      request_count++;
   endtask

   task automatic check_response();
      list_response_type seen;
      list_response_type want;
      seen.value  = rsp_result_value;
      seen.hit    = rsp_hit;
      seen.index  = rsp_found_index;
      seen.count  = rsp_entry_count;
      seen.status = rsp_status;
      response_count++;
      if (pending_responses.size() == 0) begin
         if (mismatch_count < MAX_REPORTS)
            $display("unexpected response %0d: value %0d count %0d status %0d",
                     response_count, seen.value, seen.count, seen.status);
         mismatch_count++;
      end else begin
         want = pending_responses.pop_front();
         if (seen !== want) begin
            if (mismatch_count < MAX_REPORTS) begin
               $display({"mismatch on response %0d: expected value %0d hit %0b ",
                         "index %0d count %0d status %0d"},
                        response_count, want.value, want.hit, want.index, want.count,
                        want.status);
               $display("   got value %0d hit %0b index %0d count %0d status %0d",
                        seen.value, seen.hit, seen.index, seen.count, seen.status);
            end
            mismatch_count++;
         end
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         check_response();
      rsp_stall <= ($urandom_range(99) < rsp_idle_pct);
   end

   task automatic test_empty_list();
      send_request(CMD_GETFRONT, 32'sd0, 8'd0);
      send_request(CMD_RMFRONT, -32'sd1, 8'd0);
      send_request(CMD_RMBACK, 32'sd5, 8'd0);
      send_request(CMD_RMAT, 32'sd0, 8'd0);
      send_request(CMD_GETAT, 32'sd0, 8'd0);
      send_request(CMD_ISIN, 32'sd0, 8'd0);
      send_request(CMD_INDEXOF, -32'sd1, 8'd0);
      send_request(CMD_LENGTH, 32'sd0, 8'd0);
      send_request(CMD_SPARE_LO, 32'sh7fff_ffff, 8'hff);
      send_request(CMD_SPARE_HI, 32'sh8000_0000, 8'h80);
   endtask

   task automatic test_edge_values();
      send_request(CMD_ADDAT, 32'sh7fff_ffff, 8'hff);
      send_request(CMD_ADDFRONT, 32'sh8000_0000, 8'd0);
      send_request(CMD_ADDAT, -32'sd1, 8'd1);
      send_request(CMD_ADDBACK, -32'sd1, 8'd0);
      send_request(CMD_INDEXOF, -32'sd1, 8'd0);
      send_request(CMD_ISIN, 32'sh7fff_ffff, 8'd0);
      send_request(CMD_GETAT, 32'sd0, 8'd2);
      send_request(CMD_GETAT, 32'sd0, 8'hff);
      send_request(CMD_RMAT, 32'sd0, 8'hff);
      send_request(CMD_RMAT, 32'sd0, 8'd1);
      send_request(CMD_RMBACK, 32'sd0, 8'd0);
      send_request(CMD_RMFRONT, 32'sd0, 8'd0);
      send_request(CMD_GETFRONT, 32'sd0, 8'd0);
   endtask

   task automatic test_full_list();
      while (list_len < LIST_CAP)
         send_request(CMD_ADDAT, $urandom, 8'($urandom_range(list_len)));
      send_request(CMD_ADDFRONT, 32'sd1, 8'd0);
      send_request(CMD_ADDBACK, 32'sd2, 8'd0);
      send_request(CMD_ADDAT, 32'sd3, 8'hff);
      send_request(CMD_GETAT, 32'sd0, 8'(LIST_CAP - 1));
      send_request(CMD_GETAT, 32'sd0, 8'(LIST_CAP));
      send_request(CMD_RMAT, 32'sd0, 8'(LIST_CAP - 1));
      send_request(CMD_LENGTH, 32'sd0, 8'd0);
      send_request(CMD_CLEAR, 32'sd0, 8'd0);
      send_request(CMD_GETFRONT, 32'sd0, 8'd0);
   endtask

   task automatic test_random_mix(input int n_items);
      logic [CMD_W-1:0]         cmd;
      logic signed [DATA_W-1:0] val;
      logic [POS_W-1:0]         pos;
      int                       insert_pct;
      int                       remove_pct;
      int                       roll;
      for (int k = 0; k < n_items; k++) begin
         if (k % 32 == 0) begin
            case ($urandom_range(2))
               0:       begin insert_pct = 12; remove_pct = 55; end
               1:       begin insert_pct = 35; remove_pct = 30; end
               default: begin insert_pct = 60; remove_pct = 12; end
            endcase
         end
         roll = $urandom_range(99);
         if (roll < 1) begin
            cmd = CMD_CLEAR;
         end else if (roll < 3) begin
            cmd = CMD_W'($urandom_range(CMD_SPARE_HI, CMD_SPARE_LO));
         end else if (roll < 3 + insert_pct) begin
            case ($urandom_range(2))
               0:       cmd = CMD_ADDFRONT;
               1:       cmd = CMD_ADDBACK;
               default: cmd = CMD_ADDAT;
            endcase
         end else if (roll < 3 + insert_pct + remove_pct) begin
            case ($urandom_range(2))
               0:       cmd = CMD_RMFRONT;
               1:       cmd = CMD_RMBACK;
               default: cmd = CMD_RMAT;
            endcase
         end else begin
            case ($urandom_range(4))
               0:       cmd = CMD_ISIN;
               1:       cmd = CMD_GETFRONT;
               2:       cmd = CMD_GETAT;
               3:       cmd = CMD_INDEXOF;
               default: cmd = CMD_LENGTH;
            endcase
         end
         case ($urandom_range(3))
            0:       val = (list_len != 0) ? list_values[$urandom_range(list_len - 1)] : $urandom;
            1:       val = $urandom_range(4) - 2;
            2:       val = ($urandom_range(1) == 0) ? 32'sh7fff_ffff : 32'sh8000_0000;
            default: val = $urandom;
         endcase
         pos = ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(list_len + 1));
         send_request(cmd, val, pos);
      end
   endtask

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      send_idle_pct = 16;
      rsp_idle_pct  = 48;
      test_empty_list();
      test_edge_values();
      test_full_list();
      test_random_mix(180);
      send_idle_pct = 48;
      rsp_idle_pct  = 16;
      test_random_mix(180);
      send_idle_pct = 0;
      rsp_idle_pct  = 0;
      test_random_mix(180);
      req_valid <= 1'b0;
      while (pending_responses.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("run covered %0d requests and %0d responses, peak length %0d of %0d",
               request_count, response_count, peak_len, LIST_CAP);
      $display("inserts dropped on a full list %0d, misses %0d, mismatches %0d",
               full_drops, miss_count, mismatch_count);
      if (mismatch_count == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

   initial begin
      #5_000_000;
      $display("timeout: %0d requests sent, %0d responses outstanding",
               request_count, pending_responses.size());
      $display("status: fail");
      $finish;
   end

endmodule
